[rtl/core/snemm_pkg.sv]
// Package for the signed number extractor: beat types, character codes,
// register addresses and reset values. No dependencies.

package snemm_pkg;

    localparam int unsigned CharW   = 8;
    localparam int unsigned DataW   = 32;
    localparam int unsigned MagW    = 31;
    localparam int unsigned AddrW   = 3;

    localparam logic [CharW-1:0] CharMinus = 8'h2D;
    localparam logic [CharW-1:0] CharZero  = 8'h30;
    localparam logic [CharW-1:0] CharNine  = 8'h39;

    localparam logic [MagW-1:0] MagMax = {MagW{1'b1}};

    localparam logic signed [DataW-1:0] MinStartReset = 32'sd999;
    localparam logic signed [DataW-1:0] MaxStartReset = -32'sd999;

    typedef enum logic
    {
        REG_MIN_START = 1'b0,
        REG_MAX_START = 1'b1
    } reg_index_t;

    typedef enum logic
    {
        KIND_CHAR    = 1'b0,
        KIND_SUMMARY = 1'b1
    } kind_t;

    typedef struct packed
    {
        logic [CharW-1:0] ch;
        logic             end_mark;
    } char_beat_t;

    typedef struct packed
    {
        kind_t                    kind;
        logic [CharW-1:0]         out_ch;
        logic signed [DataW-1:0]  min_value;
        logic signed [DataW-1:0]  max_value;
        logic                     overflow;
    } res_beat_t;

endpackage

[rtl/core/signed_number_extract_min_max.sv]
// Top level of the signed number extractor with running minimum and maximum.
// Depends on snemm_pkg for beat types, character codes and register map.
//
//  Channel   Direction  Handshake               Payload
//  char      in         char_valid/char_stall   char_beat (ch, end_mark)
//  res       out        res_valid/res_stall     res_beat (kind, out_ch, min, max, overflow)
//  apb       in         psel/penable/pready     paddr, pwdata, prdata
//
// A beat goes through an input register and a result register, one beat per
// cycle sustained while the input register is not stalled.
// Digits and minus signs leave no result beat.
// Reset clears the number state and loads the start registers and running values.
// A stalled result register holds its beat; the input register then stalls only
// when its beat would produce a result.

module signed_number_extract_min_max
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       char_valid,
    output logic                       char_stall,
    input  snemm_pkg::char_beat_t      char_beat,
    output logic                       res_valid,
    input  logic                       res_stall,
    output snemm_pkg::res_beat_t       res_beat,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [snemm_pkg::AddrW-1:0] paddr,
    input  logic [snemm_pkg::DataW-1:0] pwdata,
    output logic [snemm_pkg::DataW-1:0] prdata,
    output logic                       pready
);
    import snemm_pkg::*;

    logic signed [DataW-1:0] min_start_reg;
    logic signed [DataW-1:0] max_start_reg;

    logic                    in_valid_reg;
    char_beat_t              in_beat_reg;

    logic [MagW-1:0]         mag_reg;
    logic [MagW-1:0]         mag_next;
    logic                    neg_reg;
    logic                    neg_next;
    logic signed [DataW-1:0] run_min_reg;
    logic signed [DataW-1:0] run_min_next;
    logic signed [DataW-1:0] run_max_reg;
    logic signed [DataW-1:0] run_max_next;
    logic                    sat_reg;
    logic                    sat_next;

    logic                    res_valid_reg;
    res_beat_t               res_beat_reg;
    res_beat_t               res_beat_next;

    logic                    cfg_wr;
    reg_index_t              cfg_idx;
    logic                    res_load;
    logic                    advance;
    logic                    has_result;
    logic                    is_digit;
    logic                    is_minus;
    logic                    closing;
    logic [3:0]              digit;
    logic [MagW+3:0]         mag_wide;
    logic signed [DataW-1:0] num_val;
    logic signed [DataW-1:0] closed_min;
    logic signed [DataW-1:0] closed_max;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_index_t'(paddr[2]);

    always_comb
    begin
        unique case (cfg_idx)
            REG_MIN_START: prdata = min_start_reg;
            REG_MAX_START: prdata = max_start_reg;
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_start_reg <= MinStartReset;
            max_start_reg <= MaxStartReset;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_MIN_START: min_start_reg <= pwdata;
                REG_MAX_START: max_start_reg <= pwdata;
                default:       ;
            endcase
        end
    end

    assign is_minus   = !in_beat_reg.end_mark && (in_beat_reg.ch == CharMinus);
    assign is_digit   = !in_beat_reg.end_mark && (in_beat_reg.ch >= CharZero)
                        && (in_beat_reg.ch <= CharNine);
    assign has_result = !is_minus && !is_digit;
    assign res_load   = !res_valid_reg || !res_stall;
    assign advance    = in_valid_reg && (!has_result || res_load);
    assign char_stall = in_valid_reg && !advance;

    assign digit    = 4'(in_beat_reg.ch - CharZero);
    assign mag_wide = ({4'b0, mag_reg} << 3) + ({4'b0, mag_reg} << 1)
                      + {{(MagW){1'b0}}, digit};
    assign closing  = has_result && (mag_reg != '0);
    assign num_val  = neg_reg ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});

    always_comb
    begin
        closed_min = run_min_reg;
        closed_max = run_max_reg;
        if (closing && (num_val < run_min_reg))
        begin
            closed_min = num_val;
        end
        if (closing && (num_val > run_max_reg))
        begin
            closed_max = num_val;
        end
    end

    always_comb
    begin
        mag_next      = mag_reg;
        neg_next      = neg_reg;
        run_min_next  = closed_min;
        run_max_next  = closed_max;
        sat_next      = sat_reg;
        res_beat_next = '0;
        if (in_beat_reg.end_mark)
        begin
            mag_next                = '0;
            neg_next                = 1'b0;
            run_min_next            = min_start_reg;
            run_max_next            = max_start_reg;
            sat_next                = 1'b0;
            res_beat_next.kind      = KIND_SUMMARY;
            res_beat_next.min_value = closed_min;
            res_beat_next.max_value = closed_max;
            res_beat_next.overflow  = sat_reg;
        end
        else if (is_minus)
        begin
            neg_next = 1'b1;
        end
        else if (is_digit)
        begin
            if (mag_wide[MagW+3:MagW] != '0)
            begin
                mag_next = MagMax;
                sat_next = 1'b1;
            end
            else
            begin
                mag_next = mag_wide[MagW-1:0];
            end
        end
        else
        begin
            if (closing)
            begin
                mag_next = '0;
                neg_next = 1'b0;
            end
            res_beat_next.kind   = KIND_CHAR;
            res_beat_next.out_ch = in_beat_reg.ch;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!char_stall)
        begin
            in_valid_reg <= char_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!char_stall && char_valid)
        begin
            in_beat_reg <= char_beat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_reg     <= '0;
            neg_reg     <= 1'b0;
            run_min_reg <= MinStartReset;
            run_max_reg <= MaxStartReset;
            sat_reg     <= 1'b0;
        end
        else if (advance)
        begin
            mag_reg     <= mag_next;
            neg_reg     <= neg_next;
            run_min_reg <= run_min_next;
            run_max_reg <= run_max_next;
            sat_reg     <= sat_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            res_valid_reg <= advance && has_result;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load && advance && has_result)
        begin
            res_beat_reg <= res_beat_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_beat  = res_beat_reg;

    a_end_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_beat_reg.end_mark) |=> (mag_reg == '0) && !neg_reg && !sat_reg)
        else $error("End beat did not clear the number state.");

    a_char_result_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && (res_beat_reg.kind == KIND_CHAR)) |->
        (res_beat_reg.min_value == '0) && (res_beat_reg.max_value == '0)
        && !res_beat_reg.overflow)
        else $error("Character beat carries summary fields.");

    a_sign_clear_on_close: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(neg_reg) |-> $past(advance && (closing || in_beat_reg.end_mark)))
        else $error("Sign cleared without closing a number.");

    a_stall_only_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        char_stall |-> (in_valid_reg && has_result && res_valid_reg && res_stall))
        else $error("Input stalled without a blocked result.");

endmodule
